### sv/wla_pkg.sv
// ----------------------------------------------------------------------------
// wla_pkg
// Shared types and constants for the window/level autoscale block.
// ----------------------------------------------------------------------------
package wla_pkg;

  localparam int FRAME_PIXELS_DEF = 4096;

  localparam int PIX_W  = 16;
  localparam int WIN_W  = 18;   // signed room for center +/- half width
  localparam int OUT_W  = 8;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic [15:0] WIDTH_RESET  = 16'd256;
  localparam logic [15:0] CENTER_RESET = 16'd128;

  // register index, taken from paddr[2]
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_CENTER = 1'b1;

  // input commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [WIN_W-1:0] lo;   // two's complement
    logic [WIN_W-1:0] hi;   // two's complement
  } window_t;

  typedef struct packed {
    logic [PIX_W-1:0] offset;
    logic [PIX_W-1:0] peak;
    logic             last;
    logic             flat;
  } rd_job_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_HOLD
  } div_state_t;

endpackage

### sv/wla_ram.sv
// ----------------------------------------------------------------------------
// wla_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wla_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/wla_cfg.sv
// ----------------------------------------------------------------------------
// wla_cfg
// APB register file: window width and center, with clip bounds kept ready.
// ----------------------------------------------------------------------------
module wla_cfg
  import wla_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output window_t           win
);

  localparam logic [WIN_W-1:0] LO_RESET = WIN_W'(int'(CENTER_RESET) - int'(WIDTH_RESET) / 2);
  localparam logic [WIN_W-1:0] HI_RESET = WIN_W'(int'(CENTER_RESET) + int'(WIDTH_RESET) / 2);

  logic [15:0]      width_r,  width_nxt;
  logic [15:0]      center_r, center_nxt;
  logic [WIN_W-1:0] lo_r,     lo_nxt;
  logic [WIN_W-1:0] hi_r,     hi_nxt;
  logic             wr_en;
  logic [WIN_W-1:0] center_ext;
  logic [WIN_W-1:0] half_ext;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    width_nxt  = width_r;
    center_nxt = center_r;
    if (wr_en) begin
      case (paddr[2])
        REG_WIDTH:  width_nxt  = pwdata[15:0];
        REG_CENTER: center_nxt = pwdata[15:0];
        default:    width_nxt  = width_r;
      endcase
    end
    // recompute bounds from the values about to be held
    center_ext = {{(WIN_W-16){center_nxt[15]}}, center_nxt};
    half_ext   = {{(WIN_W-15){1'b0}}, width_nxt[15:1]};
    lo_nxt     = center_ext - half_ext;
    hi_nxt     = center_ext + half_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      center_r <= CENTER_RESET;
      lo_r     <= LO_RESET;
      hi_r     <= HI_RESET;
    end else begin
      width_r  <= width_nxt;
      center_r <= center_nxt;
      lo_r     <= lo_nxt;
      hi_r     <= hi_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_WIDTH:  prdata = {{(DATA_W-16){1'b0}}, width_r};
      REG_CENTER: prdata = {{(DATA_W-16){1'b0}}, center_r};
      default:    prdata = '0;
    endcase
  end

  assign win.lo = lo_r;
  assign win.hi = hi_r;

endmodule

### sv/wla_queue.sv
// ----------------------------------------------------------------------------
// wla_queue
// Short queue of read jobs between the front end and the divider.
// ----------------------------------------------------------------------------
module wla_queue
  import wla_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rd_job_t           push_job,
  input  logic              pop,
  output rd_job_t           head_job,
  output logic              empty,
  output logic [QCNT_W-1:0] count
);

  rd_job_t           slot_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r,  cnt_nxt;
  logic              do_pop;

  assign empty  = (cnt_r == '0);
  assign do_pop = pop & ~empty;

  always_comb begin
    wptr_nxt = push   ? QPTR_W'(wptr_r + 1'b1) : wptr_r;
    rptr_nxt = do_pop ? QPTR_W'(rptr_r + 1'b1) : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_job;
    end
  end

  assign head_job = slot_r[rptr_r];
  assign count    = cnt_r;

endmodule

### sv/wla_front.sv
// ----------------------------------------------------------------------------
// wla_front
// Accepts words, clips and stores loaded pixels, tracks the frame peak and
// issues store reads for read words.
// ----------------------------------------------------------------------------
module wla_front
  import wla_pkg::*;
#(
  parameter int FRAME_PIXELS = FRAME_PIXELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic              in_command,
  input  logic [PIX_W-1:0]  in_pixel_value,
  input  logic              in_frame_end,
  input  window_t           win,
  input  logic [QCNT_W-1:0] q_count,
  output logic              q_push,
  output rd_job_t           q_job
);

  localparam int AW    = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam int CNT_W = $clog2(FRAME_PIXELS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(FRAME_PIXELS);

  logic [CNT_W-1:0] loaded_r, loaded_nxt;
  logic [CNT_W-1:0] rptr_r,   rptr_nxt;
  logic [PIX_W-1:0] peak_r,   peak_nxt;
  logic             ready_r,  ready_nxt;
  logic             pend_r;
  logic             pend_last_r;
  logic             pend_flat_r;
  logic [PIX_W-1:0] pend_peak_r;

  logic             accept;
  logic             do_load;
  logic             do_read;
  logic             has_room;
  logic [CNT_W-1:0] cnt_eff;
  logic [PIX_W-1:0] peak_eff;
  logic [WIN_W-1:0] pix_ext;
  logic [WIN_W-1:0] clip;
  logic [WIN_W-1:0] diff;
  logic [PIX_W-1:0] offset;
  logic [CNT_W-1:0] idx;
  logic             idx_last;
  logic [PIX_W-1:0] ram_rdata;
  logic [QCNT_W:0]  in_flight;

  // leave a slot for the pending read and one for a new one
  assign in_flight = {1'b0, q_count} + {{QCNT_W{1'b0}}, pend_r};
  assign in_full   = (in_flight >= (QCNT_W + 1)'(QDEPTH));
  assign accept    = in_push & ~in_full;
  assign do_load   = accept & (in_command == CMD_LOAD);
  assign do_read   = accept & (in_command == CMD_READ) & ready_r & (loaded_r != '0);

  // a load after a finished frame starts a new one
  assign cnt_eff  = ready_r ? '0 : loaded_r;
  assign peak_eff = ready_r ? '0 : peak_r;
  assign has_room = (cnt_eff < CNT_MAX);

  always_comb begin
    pix_ext = {{(WIN_W-PIX_W){in_pixel_value[PIX_W-1]}}, in_pixel_value};
    if ($signed(pix_ext) < $signed(win.lo)) begin
      clip = win.lo;
    end else if ($signed(pix_ext) > $signed(win.hi)) begin
      clip = win.hi;
    end else begin
      clip = pix_ext;
    end
    diff   = clip - win.lo;
    offset = diff[PIX_W-1:0];
  end

  always_comb begin
    idx      = (rptr_r >= loaded_r) ? '0 : rptr_r;
    idx_last = ((idx + CNT_W'(1)) == loaded_r);
  end

  always_comb begin
    loaded_nxt = loaded_r;
    rptr_nxt   = rptr_r;
    peak_nxt   = peak_r;
    ready_nxt  = ready_r;
    if (do_load) begin
      loaded_nxt = cnt_eff;
      peak_nxt   = peak_eff;
      rptr_nxt   = ready_r ? '0 : rptr_r;
      ready_nxt  = in_frame_end;
      if (has_room) begin
        loaded_nxt = cnt_eff + 1'b1;
        if (offset > peak_eff) begin
          peak_nxt = offset;
        end
      end
      if (in_frame_end) begin
        rptr_nxt = '0;
      end
    end else if (do_read) begin
      rptr_nxt = idx_last ? '0 : idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= '0;
      rptr_r   <= '0;
      peak_r   <= '0;
      ready_r  <= 1'b0;
      pend_r   <= 1'b0;
    end else begin
      loaded_r <= loaded_nxt;
      rptr_r   <= rptr_nxt;
      peak_r   <= peak_nxt;
      ready_r  <= ready_nxt;
      pend_r   <= do_read;
    end
  end

  // hold job fields while the store read completes
  always_ff @(posedge clk) begin
    if (do_read) begin
      pend_last_r <= idx_last;
      pend_flat_r <= (peak_r == '0);
      pend_peak_r <= peak_r;
    end
  end

  wla_ram #(
    .WIDTH (PIX_W),
    .DEPTH (FRAME_PIXELS)
  ) u_store (
    .clk   (clk),
    .we    (do_load & has_room),
    .waddr (cnt_eff[AW-1:0]),
    .wdata (offset),
    .re    (do_read),
    .raddr (idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign q_push       = pend_r;
  assign q_job.offset = ram_rdata;
  assign q_job.peak   = pend_peak_r;
  assign q_job.last   = pend_last_r;
  assign q_job.flat   = pend_flat_r;

endmodule

### sv/wla_div.sv
// ----------------------------------------------------------------------------
// wla_div
// Back end: floor(offset * 255 / peak) by restoring division, one quotient
// bit per cycle, into a result register.
// ----------------------------------------------------------------------------
module wla_div
  import wla_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  rd_job_t          q_job,
  input  logic             q_empty,
  output logic             q_pop,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [OUT_W-1:0] out_scaled_pixel,
  output logic             out_last_pixel,
  output logic             out_flat_range
);

  localparam int NUM_W  = PIX_W + OUT_W;
  localparam int STEP_W = $clog2(OUT_W);

  div_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r;
  logic [PIX_W-1:0]  rem_r;
  logic [OUT_W-1:0]  num_lo_r;
  logic [OUT_W-1:0]  quo_r;
  logic [PIX_W-1:0]  div_r;
  logic              last_r;
  logic              flat_r;

  logic              ov_r;
  logic [OUT_W-1:0]  ov_pixel_r;
  logic              ov_last_r;
  logic              ov_flat_r;

  logic              start;
  logic              finish;
  logic              out_free;
  logic [NUM_W-1:0]  num;
  logic [PIX_W:0]    trial;
  logic [PIX_W:0]    diff;
  logic              ge;

  assign out_free = ~ov_r | out_pop;

  // offset * 255 as (offset << 8) - offset
  assign num   = {q_job.offset, {OUT_W{1'b0}}} - {{OUT_W{1'b0}}, q_job.offset};
  assign trial = {rem_r, num_lo_r[OUT_W-1]};
  assign diff  = trial - {1'b0, div_r};
  assign ge    = (trial >= {1'b0, div_r});

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      DIV_IDLE: if (!q_empty) state_nxt = DIV_RUN;
      DIV_RUN:  if (step_r == '0) state_nxt = DIV_HOLD;
      DIV_HOLD: if (out_free) state_nxt = DIV_IDLE;
      default:  state_nxt = DIV_IDLE;
    endcase
  end

  always_comb begin
    start  = 1'b0;
    finish = 1'b0;
    case (state_r)
      DIV_IDLE: start  = ~q_empty;
      DIV_HOLD: finish = out_free;
      default: begin
        start  = 1'b0;
        finish = 1'b0;
      end
    endcase
  end

  assign q_pop = start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DIV_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (finish) begin
        ov_r <= 1'b1;
      end else if (out_pop) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r    <= num[NUM_W-1:OUT_W];
      num_lo_r <= num[OUT_W-1:0];
      quo_r    <= '0;
      div_r    <= q_job.peak;
      last_r   <= q_job.last;
      flat_r   <= q_job.flat;
      step_r   <= STEP_W'(OUT_W - 1);
    end else if (state_r == DIV_RUN) begin
      rem_r    <= ge ? diff[PIX_W-1:0] : trial[PIX_W-1:0];
      num_lo_r <= {num_lo_r[OUT_W-2:0], 1'b0};
      quo_r    <= {quo_r[OUT_W-2:0], ge};
      step_r   <= step_r - 1'b1;
    end
    if (finish) begin
      // zero peak: force the pixel to zero
      ov_pixel_r <= flat_r ? '0 : quo_r;
      ov_last_r  <= last_r;
      ov_flat_r  <= flat_r;
    end
  end

  assign out_empty        = ~ov_r;
  assign out_scaled_pixel = ov_pixel_r;
  assign out_last_pixel   = ov_last_r;
  assign out_flat_range   = ov_flat_r;

endmodule

### sv/window_level_autoscale.sv
// ----------------------------------------------------------------------------
// window_level_autoscale
// Window/level contrast stretch of one frame of signed pixels to 8 bits.
// ----------------------------------------------------------------------------
// Input words arrive through in_push/in_full. A load word (command 0) clips
// the pixel to center +/- width/2, stores its offset from the lower bound and
// updates the frame peak; it produces no result. Loads run at one per cycle
// while in_full is low. Once a load carrying frame_end has gone in, each read
// word (command 1) yields the next stored pixel as floor(offset * 255 / peak),
// wrapping back to the first pixel after the last. Reads before a frame is
// complete are dropped. Results wait on out_* while out_empty is low and leave
// on out_pop. The divider works on one read at a time: it loads the job,
// develops the 8 quotient bits, then hands the result off before it takes the
// next. Up to four read jobs queue ahead of the divider, so the front keeps
// taking words while a result waits; with the receiver stalled, in_full rises
// once queued and pending reads fill the queue. Reset clears the frame, peak
// and counters; window registers go to width 256, center 128. Store contents
// are not cleared.
// ----------------------------------------------------------------------------
module window_level_autoscale
  import wla_pkg::*;
#(
  parameter int FRAME_PIXELS = FRAME_PIXELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_push,
  output logic              in_full,
  input  logic              in_command,
  input  logic [PIX_W-1:0]  in_pixel_value,
  input  logic              in_frame_end,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [OUT_W-1:0]  out_scaled_pixel,
  output logic              out_last_pixel,
  output logic              out_flat_range
);

  window_t           win;
  logic              q_push;
  rd_job_t           q_push_job;
  logic              q_pop;
  rd_job_t           q_head;
  logic              q_empty;
  logic [QCNT_W-1:0] q_count;

  wla_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .win     (win)
  );

  wla_front #(
    .FRAME_PIXELS (FRAME_PIXELS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_command     (in_command),
    .in_pixel_value (in_pixel_value),
    .in_frame_end   (in_frame_end),
    .win            (win),
    .q_count        (q_count),
    .q_push         (q_push),
    .q_job          (q_push_job)
  );

  wla_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_push_job),
    .pop      (q_pop),
    .head_job (q_head),
    .empty    (q_empty),
    .count    (q_count)
  );

  wla_div u_div (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_job            (q_head),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_scaled_pixel (out_scaled_pixel),
    .out_last_pixel   (out_last_pixel),
    .out_flat_range   (out_flat_range)
  );

endmodule
